/* design/pts_pkg.sv */
package pts_pkg;

  localparam int unsigned TASK_SLOTS      = 16;
  localparam int unsigned PRIORITY_LEVELS = 32;
  localparam int unsigned TW  = $clog2(TASK_SLOTS);       // slot index width
  localparam int unsigned LW  = TW + 1;                   // link width, holds null
  localparam int unsigned PW  = $clog2(PRIORITY_LEVELS);  // priority width
  localparam int unsigned PLW = PW + 1;                   // level result, holds none

  localparam logic [LW-1:0] NO_TASK       = LW'(TASK_SLOTS);
  localparam logic [31:0]   TIMEOUT_LIMIT = 32'h7FFF_FFFE;
  localparam logic [31:0]   WAKE_NEVER    = 32'hFFFF_FFFF;

  // event kinds
  localparam logic [3:0] KIND_TICK     = 4'd0;
  localparam logic [3:0] KIND_READY    = 4'd1;
  localparam logic [3:0] KIND_UNREADY  = 4'd2;
  localparam logic [3:0] KIND_BLOCK    = 4'd3;
  localparam logic [3:0] KIND_UNBLOCK  = 4'd4;
  localparam logic [3:0] KIND_UNDELAY  = 4'd5;
  localparam logic [3:0] KIND_START    = 4'd6;
  localparam logic [3:0] KIND_SUSPEND  = 4'd7;
  localparam logic [3:0] KIND_RESUME   = 4'd8;
  localparam logic [3:0] KIND_SW_DONE  = 4'd9;

  // configuration register indexes
  localparam logic CFG_PREEMPT = 1'b0;
  localparam logic CFG_SLICE   = 1'b1;

  typedef enum logic [2:0] {
    MODE_ABSENT  = 3'd0,
    MODE_READY   = 3'd1,
    MODE_RUNNING = 3'd2,
    MODE_DELAYED = 3'd3,
    MODE_BLOCKED = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    RUN_IDLE = 2'd0,
    RUN_ON   = 2'd1,
    RUN_SUSP = 2'd2
  } run_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DREM,
    ST_RREM,
    ST_SETRDY,
    ST_RPUSH,
    ST_BLKSET,
    ST_DINS,
    ST_UCHK,
    ST_UDEC,
    ST_DECIDE,
    ST_WAKE,
    ST_TSCHED,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        add;   // 1: a + b, 0: a - b
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        not_after;  // signed a - b is zero or negative
  } alu_rsp_t;

endpackage

/* design/pts_if.sv */
interface pts_in_if;
  logic                       valid;
  logic                       ready;
  logic [3:0]                 kind;
  logic [3:0]                 task_req;
  logic [4:0]                 priority_req;
  logic [31:0]                ticks;

  modport source (output valid, kind, task_req, priority_req, ticks, input ready);
  modport sink   (input valid, kind, task_req, priority_req, ticks, output ready);
endinterface

interface pts_out_if;
  logic        valid;
  logic        ready;
  logic        switch_request;
  logic [4:0]  switch_target;
  logic [4:0]  current_task;
  logic [15:0] woken_mask;
  logic        none_ready;
  logic [31:0] tick_now;

  modport source (output valid, switch_request, switch_target, current_task, woken_mask,
                  none_ready, tick_now, input ready);
  modport sink   (input valid, switch_request, switch_target, current_task, woken_mask,
                  none_ready, tick_now, output ready);
endinterface

/* design/pts_alu.sv */
// Shared add / subtract unit with wrap-safe time compare
module pts_alu (
  input  pts_pkg::alu_req_t req_i,
  output pts_pkg::alu_rsp_t rsp_o
);
  logic [31:0] diff;

  assign diff          = req_i.a - req_i.b;
  assign rsp_o.sum     = req_i.add ? (req_i.a + req_i.b) : diff;
  assign rsp_o.not_after = (diff == 32'd0) || diff[31];
endmodule

/* design/priority_task_scheduler.sv */
// Simple events pass from the latched request through ST_DISPATCH and ST_DONE to the
// result register; block walks the delay list one entry per cycle; a tick wakes expired
// tasks one at a time through ST_WAKE, ST_DREM and ST_RPUSH.
// One shared add/compare unit sets the step count.
// Throughput: one event at a time; the next is taken once the result is registered.
// Reset: asynchronous, active low; all rings and lists empty, scheduler not started.
module priority_task_scheduler (
  input  logic            clk_i,
  input  logic            rst_ni,
  pts_in_if.sink          req_i,
  pts_out_if.source       res_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic            cfg_data_i
);
  localparam int unsigned N  = pts_pkg::TASK_SLOTS;
  localparam int unsigned P  = pts_pkg::PRIORITY_LEVELS;
  localparam int unsigned TW = pts_pkg::TW;
  localparam int unsigned LW = pts_pkg::LW;
  localparam int unsigned PW = pts_pkg::PW;

  pts_pkg::state_e state_q, state_d;

  logic [PW-1:0]          prio_q [N];
  logic [PW-1:0]          prio_d [N];
  pts_pkg::mode_e         mode_q [N];
  pts_pkg::mode_e         mode_d [N];
  logic [31:0]            wake_q [N];
  logic [31:0]            wake_d [N];
  logic [LW-1:0]          nxt_q  [N];
  logic [LW-1:0]          nxt_d  [N];
  logic [LW-1:0]          prv_q  [N];
  logic [LW-1:0]          prv_d  [N];
  logic [LW-1:0]          head_q [P];
  logic [LW-1:0]          head_d [P];
  logic [P-1:0]           mask_q, mask_d;
  logic [LW-1:0]          dhead_q, dhead_d;
  logic [31:0]            now_q, now_d;
  pts_pkg::run_e          runm_q, runm_d;
  logic [LW-1:0]          running_q, running_d;
  logic [LW-1:0]          pending_q, pending_d;
  logic                   preempt_q, slice_q;

  // latched request
  logic [3:0]             kind_q, kind_d;
  logic [TW-1:0]          t_q, t_d;
  logic [PW-1:0]          rprio_q, rprio_d;
  logic [31:0]            ticks_q, ticks_d;
  logic                   slot_ok_q, slot_ok_d;
  logic                   raised_q, raised_d;
  logic [15:0]            woken_q, woken_d;
  logic [LW-1:0]          cur_q, cur_d;
  logic [LW-1:0]          prev_q, prev_d;

  // output register
  logic                   ovalid_q, ovalid_d;
  logic                   osw_q, osw_d;
  logic [4:0]             otgt_q, otgt_d;
  logic [4:0]             ocur_q, ocur_d;
  logic [15:0]            owoken_q, owoken_d;
  logic                   onone_q, onone_d;
  logic [31:0]            onow_q, onow_d;

  pts_pkg::alu_req_t      alu_req;
  pts_pkg::alu_rsp_t      alu_rsp;

  pts_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // lowest set bit of the ready bitmap, P when empty
  function automatic logic [PW:0] best_level(input logic [P-1:0] m);
    logic [PW:0] r;
    r = (PW+1)'(P);
    for (int i = P - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = (PW+1)'(i);
      end
    end
    return r;
  endfunction

  assign req_i.ready = (state_q == pts_pkg::ST_IDLE);

  assign res_o.valid          = ovalid_q;
  assign res_o.switch_request = osw_q;
  assign res_o.switch_target  = otgt_q;
  assign res_o.current_task   = ocur_q;
  assign res_o.woken_mask     = owoken_q;
  assign res_o.none_ready     = onone_q;
  assign res_o.tick_now       = onow_q;

  // Route operands into the shared unit
  always_comb begin
    alu_req.add = 1'b0;
    alu_req.a   = now_q;
    alu_req.b   = 32'd1;
    case (state_q)
      pts_pkg::ST_DISPATCH: begin
        alu_req.add = 1'b1;
      end
      pts_pkg::ST_BLKSET: begin
        alu_req.add = 1'b1;
        alu_req.b   = ticks_q;
      end
      pts_pkg::ST_WAKE: begin
        alu_req.a = wake_q[dhead_q[TW-1:0]];
        alu_req.b = now_q;
      end
      pts_pkg::ST_DINS: begin
        alu_req.a = wake_q[cur_q[TW-1:0]];
        alu_req.b = wake_q[t_q];
      end
      default: begin
      end
    endcase
  end

  // Sequencer: next state and all state updates
  always_comb begin
    logic [PW:0]    top;
    logic [PW-1:0]  p;
    logic [LW-1:0]  h, tl, n, v, nx, tlink;
    logic           busy_t, may_sw;

    state_d   = state_q;
    prio_d    = prio_q;
    mode_d    = mode_q;
    wake_d    = wake_q;
    nxt_d     = nxt_q;
    prv_d     = prv_q;
    head_d    = head_q;
    mask_d    = mask_q;
    dhead_d   = dhead_q;
    now_d     = now_q;
    runm_d    = runm_q;
    running_d = running_q;
    pending_d = pending_q;
    kind_d    = kind_q;
    t_d       = t_q;
    rprio_d   = rprio_q;
    ticks_d   = ticks_q;
    slot_ok_d = slot_ok_q;
    raised_d  = raised_q;
    woken_d   = woken_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    ovalid_d  = ovalid_q;
    osw_d     = osw_q;
    otgt_d    = otgt_q;
    ocur_d    = ocur_q;
    owoken_d  = owoken_q;
    onone_d   = onone_q;
    onow_d    = onow_q;

    top    = best_level(mask_q);
    p      = prio_q[t_q];
    h      = head_q[p];
    tl     = prv_q[h[TW-1:0]];
    n      = nxt_q[t_q];
    v      = prv_q[t_q];
    nx     = head_q[top[PW-1:0]];
    tlink  = {1'b0, t_q};
    busy_t = (mode_q[t_q] == pts_pkg::MODE_READY) || (mode_q[t_q] == pts_pkg::MODE_RUNNING);
    may_sw = preempt_q || (running_q == pts_pkg::NO_TASK) ||
             (mode_q[running_q[TW-1:0]] != pts_pkg::MODE_RUNNING);

    // drop the result once taken
    if (res_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      pts_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          kind_d    = req_i.kind;
          t_d       = req_i.task_req[TW-1:0];
          slot_ok_d = ({1'b0, req_i.task_req} < 5'(N));
          rprio_d   = ({1'b0, req_i.priority_req} >= 6'(P)) ? PW'(P - 1)
                                                            : req_i.priority_req[PW-1:0];
          ticks_d   = req_i.ticks;
          raised_d  = 1'b0;
          woken_d   = '0;
          state_d   = pts_pkg::ST_DISPATCH;
        end
      end

      pts_pkg::ST_DISPATCH: begin
        state_d = pts_pkg::ST_DONE;
        case (kind_q)
          pts_pkg::KIND_TICK: begin
            if (runm_q == pts_pkg::RUN_ON) begin
              now_d   = alu_rsp.sum;
              state_d = pts_pkg::ST_WAKE;
            end
          end
          pts_pkg::KIND_READY: begin
            if (slot_ok_q && !busy_t) begin
              state_d = (mode_q[t_q] == pts_pkg::MODE_DELAYED) ? pts_pkg::ST_DREM
                                                               : pts_pkg::ST_SETRDY;
            end
          end
          pts_pkg::KIND_UNREADY: begin
            if (slot_ok_q && busy_t) begin
              state_d = pts_pkg::ST_RREM;
            end
          end
          pts_pkg::KIND_BLOCK: begin
            if (slot_ok_q) begin
              if (busy_t) begin
                state_d = pts_pkg::ST_RREM;
              end else if (mode_q[t_q] == pts_pkg::MODE_DELAYED) begin
                state_d = pts_pkg::ST_DREM;
              end else begin
                state_d = pts_pkg::ST_BLKSET;
              end
            end
          end
          pts_pkg::KIND_UNBLOCK: begin
            if (slot_ok_q) begin
              state_d = (mode_q[t_q] == pts_pkg::MODE_DELAYED) ? pts_pkg::ST_DREM
                                                               : pts_pkg::ST_UCHK;
            end
          end
          pts_pkg::KIND_UNDELAY: begin
            if (slot_ok_q && mode_q[t_q] == pts_pkg::MODE_DELAYED) begin
              state_d = pts_pkg::ST_DREM;
            end
          end
          pts_pkg::KIND_START: begin
            if (runm_q == pts_pkg::RUN_IDLE) begin
              runm_d = pts_pkg::RUN_ON;
              if (top[PW]) begin
                running_d = pts_pkg::NO_TASK;
              end else begin
                running_d = nx;
                if (nx != pts_pkg::NO_TASK) begin
                  mode_d[nx[TW-1:0]] = pts_pkg::MODE_RUNNING;
                end
              end
            end
          end
          pts_pkg::KIND_SUSPEND: begin
            if (runm_q != pts_pkg::RUN_IDLE) begin
              runm_d = pts_pkg::RUN_SUSP;
            end
          end
          pts_pkg::KIND_RESUME: begin
            if (runm_q != pts_pkg::RUN_IDLE) begin
              runm_d  = pts_pkg::RUN_ON;
              state_d = pts_pkg::ST_DECIDE;
            end
          end
          pts_pkg::KIND_SW_DONE: begin
            if (pending_q != pts_pkg::NO_TASK) begin
              pending_d = pts_pkg::NO_TASK;
              if (mode_q[pending_q[TW-1:0]] == pts_pkg::MODE_READY ||
                  (pending_q == running_q &&
                   mode_q[pending_q[TW-1:0]] == pts_pkg::MODE_RUNNING)) begin
                if (running_q != pts_pkg::NO_TASK &&
                    mode_q[running_q[TW-1:0]] == pts_pkg::MODE_RUNNING) begin
                  mode_d[running_q[TW-1:0]] = pts_pkg::MODE_READY;
                end
                mode_d[pending_q[TW-1:0]] = pts_pkg::MODE_RUNNING;
                running_d = pending_q;
              end
            end
          end
          default: begin
          end
        endcase
      end

      // unlink the task from the delay list
      pts_pkg::ST_DREM: begin
        if (v != pts_pkg::NO_TASK) begin
          nxt_d[v[TW-1:0]] = n;
        end else begin
          dhead_d = n;
        end
        if (n != pts_pkg::NO_TASK) begin
          prv_d[n[TW-1:0]] = v;
        end
        nxt_d[t_q] = pts_pkg::NO_TASK;
        prv_d[t_q] = pts_pkg::NO_TASK;
        case (kind_q)
          pts_pkg::KIND_TICK:    state_d = pts_pkg::ST_RPUSH;
          pts_pkg::KIND_READY:   state_d = pts_pkg::ST_SETRDY;
          pts_pkg::KIND_BLOCK:   state_d = pts_pkg::ST_BLKSET;
          pts_pkg::KIND_UNBLOCK: state_d = pts_pkg::ST_UCHK;
          default: begin
            mode_d[t_q] = pts_pkg::MODE_BLOCKED;
            state_d     = pts_pkg::ST_DONE;
          end
        endcase
      end

      // unlink the task from its ready ring
      pts_pkg::ST_RREM: begin
        if (n == tlink) begin
          head_d[p] = pts_pkg::NO_TASK;
          mask_d[p] = 1'b0;
        end else begin
          nxt_d[v[TW-1:0]] = n;
          prv_d[n[TW-1:0]] = v;
          if (head_q[p] == tlink) begin
            head_d[p] = n;
          end
        end
        nxt_d[t_q] = pts_pkg::NO_TASK;
        prv_d[t_q] = pts_pkg::NO_TASK;
        if (kind_q == pts_pkg::KIND_UNREADY) begin
          mode_d[t_q] = pts_pkg::MODE_ABSENT;
          state_d     = pts_pkg::ST_DONE;
        end else begin
          state_d = pts_pkg::ST_BLKSET;
        end
      end

      pts_pkg::ST_SETRDY: begin
        prio_d[t_q] = rprio_q;
        mode_d[t_q] = pts_pkg::MODE_READY;
        state_d     = pts_pkg::ST_RPUSH;
      end

      // append the task at the tail of its ring
      pts_pkg::ST_RPUSH: begin
        if (h == pts_pkg::NO_TASK) begin
          nxt_d[t_q] = tlink;
          prv_d[t_q] = tlink;
          head_d[p]  = tlink;
        end else begin
          nxt_d[t_q]          = h;
          prv_d[t_q]          = tl;
          nxt_d[tl[TW-1:0]]   = tlink;
          prv_d[h[TW-1:0]]    = tlink;
        end
        mask_d[p] = 1'b1;
        case (kind_q)
          pts_pkg::KIND_TICK: begin
            mode_d[t_q] = pts_pkg::MODE_READY;
            woken_d     = woken_q | (16'd1 << t_q);
            state_d     = pts_pkg::ST_WAKE;
          end
          pts_pkg::KIND_UNBLOCK: state_d = pts_pkg::ST_UDEC;
          default:               state_d = pts_pkg::ST_DONE;
        endcase
      end

      pts_pkg::ST_BLKSET: begin
        if (ticks_q > pts_pkg::TIMEOUT_LIMIT) begin
          wake_d[t_q] = pts_pkg::WAKE_NEVER;
          mode_d[t_q] = pts_pkg::MODE_BLOCKED;
          state_d     = pts_pkg::ST_DONE;
        end else begin
          wake_d[t_q] = alu_rsp.sum;
          mode_d[t_q] = pts_pkg::MODE_DELAYED;
          cur_d       = dhead_q;
          prev_d      = pts_pkg::NO_TASK;
          state_d     = pts_pkg::ST_DINS;
        end
      end

      // walk the delay list one entry per cycle, then link in
      pts_pkg::ST_DINS: begin
        if (cur_q != pts_pkg::NO_TASK && alu_rsp.not_after) begin
          prev_d = cur_q;
          cur_d  = nxt_q[cur_q[TW-1:0]];
        end else begin
          nxt_d[t_q] = cur_q;
          prv_d[t_q] = prev_q;
          if (prev_q == pts_pkg::NO_TASK) begin
            dhead_d = tlink;
          end else begin
            nxt_d[prev_q[TW-1:0]] = tlink;
          end
          if (cur_q != pts_pkg::NO_TASK) begin
            prv_d[cur_q[TW-1:0]] = tlink;
          end
          state_d = pts_pkg::ST_DONE;
        end
      end

      pts_pkg::ST_UCHK: begin
        if (!busy_t) begin
          mode_d[t_q] = pts_pkg::MODE_READY;
          state_d     = pts_pkg::ST_RPUSH;
        end else begin
          state_d = pts_pkg::ST_UDEC;
        end
      end

      pts_pkg::ST_UDEC: begin
        if (runm_q == pts_pkg::RUN_ON &&
            (running_q == pts_pkg::NO_TASK || p < prio_q[running_q[TW-1:0]])) begin
          state_d = pts_pkg::ST_DECIDE;
        end else begin
          state_d = pts_pkg::ST_DONE;
        end
      end

      pts_pkg::ST_DECIDE: begin
        if (!top[PW] && nx != running_q && may_sw) begin
          pending_d = nx;
          raised_d  = 1'b1;
        end
        state_d = pts_pkg::ST_DONE;
      end

      // wake the delay list head while it has expired
      pts_pkg::ST_WAKE: begin
        if (dhead_q != pts_pkg::NO_TASK && alu_rsp.not_after) begin
          t_d     = dhead_q[TW-1:0];
          state_d = pts_pkg::ST_DREM;
        end else begin
          state_d = pts_pkg::ST_TSCHED;
        end
      end

      // preempt or rotate the running ring
      pts_pkg::ST_TSCHED: begin
        if (!top[PW]) begin
          if (nx != running_q) begin
            if (may_sw) begin
              pending_d = nx;
              raised_d  = 1'b1;
            end
          end else if (slice_q && running_q != pts_pkg::NO_TASK &&
                       mode_q[running_q[TW-1:0]] == pts_pkg::MODE_RUNNING &&
                       nxt_q[nx[TW-1:0]] != nx) begin
            head_d[top[PW-1:0]] = nxt_q[nx[TW-1:0]];
            pending_d           = nxt_q[nx[TW-1:0]];
            raised_d            = 1'b1;
          end
        end
        state_d = pts_pkg::ST_DONE;
      end

      // register the result once the slot is free
      pts_pkg::ST_DONE: begin
        if (!ovalid_q || res_o.ready) begin
          ovalid_d = 1'b1;
          osw_d    = raised_q;
          otgt_d   = 5'(pending_q);
          ocur_d   = 5'(running_q);
          owoken_d = woken_q;
          onone_d  = (mask_q == '0);
          onow_d   = now_q;
          state_d  = pts_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = pts_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and table registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pts_pkg::ST_IDLE;
      for (int i = 0; i < N; i++) begin
        prio_q[i] <= '0;
        mode_q[i] <= pts_pkg::MODE_ABSENT;
        nxt_q[i]  <= pts_pkg::NO_TASK;
        prv_q[i]  <= pts_pkg::NO_TASK;
      end
      for (int i = 0; i < P; i++) begin
        head_q[i] <= pts_pkg::NO_TASK;
      end
      mask_q    <= '0;
      dhead_q   <= pts_pkg::NO_TASK;
      now_q     <= '0;
      runm_q    <= pts_pkg::RUN_IDLE;
      running_q <= pts_pkg::NO_TASK;
      pending_q <= pts_pkg::NO_TASK;
      preempt_q <= 1'b1;
      slice_q   <= 1'b1;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      prio_q    <= prio_d;
      mode_q    <= mode_d;
      nxt_q     <= nxt_d;
      prv_q     <= prv_d;
      head_q    <= head_d;
      mask_q    <= mask_d;
      dhead_q   <= dhead_d;
      now_q     <= now_d;
      runm_q    <= runm_d;
      running_q <= running_d;
      pending_q <= pending_d;
      ovalid_q  <= ovalid_d;
      if (cfg_we_i && cfg_idx_i == pts_pkg::CFG_PREEMPT) begin
        preempt_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == pts_pkg::CFG_SLICE) begin
        slice_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    wake_q    <= wake_d;
    kind_q    <= kind_d;
    t_q       <= t_d;
    rprio_q   <= rprio_d;
    ticks_q   <= ticks_d;
    slot_ok_q <= slot_ok_d;
    raised_q  <= raised_d;
    woken_q   <= woken_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    osw_q     <= osw_d;
    otgt_q    <= otgt_d;
    ocur_q    <= ocur_d;
    owoken_q  <= owoken_d;
    onone_q   <= onone_d;
    onow_q    <= onow_d;
  end

endmodule
